// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file kdq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/kdq_pkg.sv =====
package kdq_pkg;

  localparam int KEY_COUNT   = 3;
  localparam int QUEUE_DEPTH = 20;
  localparam int PIN_BITS    = 3;
  localparam int HOLD_W      = 8;

  localparam int KEY_W  = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;

  localparam logic [HOLD_W-1:0] HOLD_TOP          = '1;
  localparam logic [HOLD_W-1:0] PRESS_TICKS_RESET = HOLD_W'(10);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic STATUS_DOWN = 1'b0;
  localparam logic STATUS_UP   = 1'b1;

  // Key index answered on a pop of an empty ring.
  localparam logic [1:0] EMPTY_INDEX = 2'(KEY_COUNT % 4);

  typedef struct packed {
    logic       kind;
    logic [2:0] pin_levels;
  } in_t;

  typedef struct packed {
    logic [1:0] key_index;
    logic       key_status;
  } out_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [KEY_W-1:0] data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
  } ram_rd_t;

endpackage

// ===== rtl/core/kdq_ram.sv =====
module kdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/kdq_lane.sv =====
module kdq_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      tick,
  input  logic                      pin_low,
  input  logic [kdq_pkg::HOLD_W-1:0] press_ticks,
  output logic                      hit
);

  logic [kdq_pkg::HOLD_W-1:0] count_r, count_nxt;
  logic                       below_top;

  assign below_top = (count_r != kdq_pkg::HOLD_TOP);

  // Flag a key-down when the count steps onto the threshold.
  assign hit = tick && pin_low && below_top &&
               ((count_r + kdq_pkg::HOLD_W'(1)) == press_ticks);

  always_comb begin
    count_nxt = count_r;
    if (tick) begin
      if (!pin_low) begin
        count_nxt = '0;
      end else if (below_top) begin
        count_nxt = count_r + kdq_pkg::HOLD_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/kdq_merge.sv =====
module kdq_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick,
  input  logic [kdq_pkg::KEY_COUNT-1:0] hits,
  input  logic                         pop,
  output logic                         busy,
  output logic                         empty,
  output kdq_pkg::ram_wr_t             wr,
  output kdq_pkg::ram_rd_t             rd
);

  logic [kdq_pkg::KEY_COUNT-1:0] mask_r, mask_nxt;
  logic [kdq_pkg::PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt, rd_ptr_inc;
  logic [kdq_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [kdq_pkg::SUM_W-1:0]     slot_sum;
  logic [kdq_pkg::PTR_W-1:0]     tail_slot;
  logic [kdq_pkg::KEY_W-1:0]     pick;
  logic                          full;

  assign busy  = (mask_r != '0);
  assign empty = (fill_r == '0);
  assign full  = (fill_r == kdq_pkg::FILL_W'(kdq_pkg::QUEUE_DEPTH));

  assign rd_ptr_inc = (rd_ptr_r == kdq_pkg::PTR_W'(kdq_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : rd_ptr_r + kdq_pkg::PTR_W'(1);

  assign slot_sum  = kdq_pkg::SUM_W'(rd_ptr_r) + kdq_pkg::SUM_W'(fill_r);
  assign tail_slot = (slot_sum >= kdq_pkg::SUM_W'(kdq_pkg::QUEUE_DEPTH)) ?
                     kdq_pkg::PTR_W'(slot_sum - kdq_pkg::SUM_W'(kdq_pkg::QUEUE_DEPTH)) :
                     kdq_pkg::PTR_W'(slot_sum);

  // Lowest pending key goes first.
  always_comb begin
    pick = '0;
    for (int i = kdq_pkg::KEY_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = kdq_pkg::KEY_W'(i);
      end
    end
  end

  assign wr.en   = busy;
  assign wr.addr = full ? rd_ptr_r : tail_slot;
  assign wr.data = pick;

  assign rd.en   = pop && !empty;
  assign rd.addr = rd_ptr_r;

  always_comb begin
    mask_nxt   = mask_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (busy) begin
      mask_nxt = mask_r & (mask_r - kdq_pkg::KEY_COUNT'(1));
      if (full) begin
        rd_ptr_nxt = rd_ptr_inc;
      end else begin
        fill_nxt = fill_r + kdq_pkg::FILL_W'(1);
      end
    end else if (tick) begin
      mask_nxt = hits;
    end else if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_inc;
      fill_nxt   = fill_r - kdq_pkg::FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      mask_r   <= mask_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// ===== rtl/core/key_debounce_event_queue.sv =====
// Key debouncer with a key-down event ring.
//
// Input channel (in_valid / in_stall / in_data): each request is either a
// scan tick carrying the three active-low pin levels, or a pop request.
// Result channel (out_valid / out_stall / out_data): one result per pop,
// none per tick. An empty ring answers key index 3 with status up.
// Config port: cfg_wr_en writes cfg_wr_data into the press threshold.
//
// Timing: each key-down event a tick raises is written into the ring
// one per cycle, and in_stall stays high until all of them (at most three)
// are written, since the ring has a single write port. A pop result
// appears in the cycle after acceptance, as the ring read is registered.
// Every request, tick or pop, is held off while events drain or while a
// result waits and the receiver stalls.
//
// Reset (rst_n low, synchronous) clears the hold counters, the ring
// pointers and the output valid, and loads the threshold with 10. Ring
// contents need no clearing. While out_stall is high the result holds.
module key_debounce_event_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  kdq_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output kdq_pkg::out_t               out_data,
  input  logic                        cfg_wr_en,
  input  logic [kdq_pkg::HOLD_W-1:0]  cfg_wr_data
);

  logic [kdq_pkg::HOLD_W-1:0]    press_ticks_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          empty_r;
  logic                          in_fire, tick, pop;
  logic                          busy, empty;
  logic [kdq_pkg::KEY_COUNT-1:0] hits;
  logic [kdq_pkg::KEY_W-1:0]     rd_key;
  kdq_pkg::ram_wr_t              wr;
  kdq_pkg::ram_rd_t              rd;

  // Stall while events drain, or while a pending result cannot leave.
  assign in_stall = busy || (out_valid_r && out_stall);
  assign in_fire  = in_valid && !in_stall;
  assign tick     = in_fire && (in_data.kind == kdq_pkg::KIND_TICK);
  assign pop      = in_fire && (in_data.kind == kdq_pkg::KIND_POP);

  // One counter lane per key; keys beyond the pin field read as released.
  for (genvar g = 0; g < kdq_pkg::KEY_COUNT; g++) begin : g_lane
    logic pin_low;
    if (g < kdq_pkg::PIN_BITS) begin : g_pin
      assign pin_low = !in_data.pin_levels[g];
    end else begin : g_none
      assign pin_low = 1'b0;
    end
    kdq_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick        (tick),
      .pin_low     (pin_low),
      .press_ticks (press_ticks_r),
      .hit         (hits[g])
    );
  end

  // Merge lane hits in key order and run the ring pointers.
  kdq_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (tick),
    .hits  (hits),
    .pop   (pop),
    .busy  (busy),
    .empty (empty),
    .wr    (wr),
    .rd    (rd)
  );

  kdq_ram #(
    .WIDTH (kdq_pkg::KEY_W),
    .DEPTH (kdq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd.en),
    .rd_addr (rd.addr),
    .rd_data (rd_key)
  );

  // Raise valid on a pop, drop it once the receiver takes the result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= kdq_pkg::PRESS_TICKS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        press_ticks_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Remember whether the pop found the ring empty.
  always_ff @(posedge clk) begin
    if (pop) begin
      empty_r <= empty;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.key_index  = empty_r ? kdq_pkg::EMPTY_INDEX : 2'(rd_key);
  assign out_data.key_status = empty_r ? kdq_pkg::STATUS_UP : kdq_pkg::STATUS_DOWN;

endmodule

// ===== rtl/core/kdq_checker.sv =====
`include "assert_macros.svh"

module kdq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input kdq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input kdq_pkg::out_t out_data
);

  logic pop_fire;
  assign pop_fire = in_valid && !in_stall && (in_data.kind == kdq_pkg::KIND_POP);

  // An up status comes only with the empty-ring key index.
  `AST_IMPLY(a_up_is_empty, clk, rst_n,
             out_valid && (out_data.key_status == kdq_pkg::STATUS_UP),
             out_data.key_index == kdq_pkg::EMPTY_INDEX)

  // Every accepted pop shows a result on the next cycle.
  `AST_NEXT(a_pop_result, clk, rst_n, pop_fire, out_valid)

  // A stalled result stays valid and unchanged.
  `AST_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid)
  `AST_NEXT(a_hold_data, clk, rst_n, out_valid && out_stall, $stable(out_data))

endmodule

bind key_debounce_event_queue kdq_checker u_kdq_checker (.*);

// ===== tb/key_debounce_event_queue_checker.sv =====
module key_debounce_event_queue_checker
  import kdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_t               in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_t              out_data,
  input  logic              cfg_wr_en,
  input  logic [HOLD_W-1:0] cfg_wr_data,
  output int                failure_count,
  output int                results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HOLD_W-1:0] press_threshold;
  logic [HOLD_W-1:0] hold_ticks [KEY_COUNT];
  logic [1:0]        queued_keys [$];
  out_t              awaited_results [$];
  int                failures = 0;

  task automatic report_mismatch(input string msg);
    failures++;
    $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Count held keys, clear released ones, queue key-down events in key order.
  function automatic void apply_scan_tick(input logic [PIN_BITS-1:0] pins);
    for (int k = 0; k < KEY_COUNT; k++) begin
      if (k < PIN_BITS && !pins[k]) begin
        if (hold_ticks[k] != HOLD_TOP) begin
          hold_ticks[k]++;
          if (hold_ticks[k] == press_threshold) begin
            if (queued_keys.size() == QUEUE_DEPTH) begin
              void'(queued_keys.pop_front());
            end
            queued_keys.push_back(2'(k));
          end
        end
      end else begin
        hold_ticks[k] = '0;
      end
    end
  endfunction

  function automatic void predict_pop();
    out_t want;
    if (queued_keys.size() == 0) begin
      want.key_index  = EMPTY_INDEX;
      want.key_status = STATUS_UP;
    end else begin
      want.key_index  = queued_keys.pop_front();
      want.key_status = STATUS_DOWN;
    end
    awaited_results.push_back(want);
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("result %0d/%0d with no pop waiting",
                                got.key_index, got.key_status));
    end else begin
      want = awaited_results.pop_front();
      if (got.key_index !== want.key_index) begin
        report_mismatch($sformatf("key_index %0d, want %0d", got.key_index, want.key_index));
      end
      if (got.key_status !== want.key_status) begin
        report_mismatch($sformatf("key_status %0d, want %0d",
                                  got.key_status, want.key_status));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      press_threshold = PRESS_TICKS_RESET;
      for (int k = 0; k < KEY_COUNT; k++) begin
        hold_ticks[k] = '0;
      end
      queued_keys.delete();
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) begin
        press_threshold = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_TICK) begin
          apply_scan_tick(in_data.pin_levels);
        end else begin
          predict_pop();
        end
      end
      if (out_valid && !out_stall) begin
        check_result(out_data);
      end
    end
    failure_count <= failures;
    results_due   <= awaited_results.size();
  end

endmodule

// ===== tb/tb_key_debounce_event_queue.sv =====
module tb_key_debounce_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import kdq_pkg::*;

  localparam int RESET_CYCLES  = 11;
  // After a tick the block writes its events, at most three, into the ring.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall;
  out_t              out_data;
  logic              cfg_wr_en;
  logic [HOLD_W-1:0] cfg_wr_data;

  int failures;
  int results_due;
  int cycle_count;
  // quiet: final stretch with no idling on either side.
  // calm:  per-segment stretch with no sender gaps.
  bit quiet = 1'b0;
  bit calm  = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  key_debounce_event_queue dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  key_debounce_event_queue_checker event_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .failure_count (failures),
    .results_due   (results_due)
  );

  // Send one request. Called at a falling edge; returns at the falling edge
  // after acceptance so the next request can follow back to back with valid
  // held high. Occasionally drop valid for a random gap first.
  task automatic send_request(input logic kind, input logic [2:0] pins);
    if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid           = 1'b1;
    in_data.kind       = kind;
    in_data.pin_levels = pins;
    // Hold the request until the block takes it.
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stop sending, wait for every predicted result, then let the ring write
  // path finish any events still in flight. Leaves us at a falling edge.
  task automatic drain_and_settle();
    in_valid = 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the press threshold; only called while the block is idle.
  task automatic write_threshold(input logic [HOLD_W-1:0] ticks);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = ticks;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  // Random traffic for one threshold setting. Most of it is key holds sized
  // around the threshold so events actually fire, with bounce noise, pops
  // mixed in, ring floods to force overwrite, and full drains to reach the
  // empty answer. With saturate set, open with a hold past the counter top.
  task automatic run_phase(input int thr, input int budget, input bit saturate);
    int         sent;
    int         hold_len;
    int         pops;
    bit         flood;
    logic [2:0] pins;
    logic [2:0] noisy;
    sent = 0;
    while (sent < budget) begin
      calm  = ($urandom_range(0, 3) == 0);
      flood = 1'b0;
      pins  = 3'($urandom_range(0, 7));
      if (saturate && sent == 0) begin
        pins[$urandom_range(0, 2)] = 1'b0;
        hold_len = 270;
      end else begin
        case ($urandom_range(0, 6))
          0, 1: hold_len = $urandom_range(1, 4);
          2, 3: hold_len = (thr > 1) ? $urandom_range(thr - 1, thr + 1) : $urandom_range(1, 2);
          4:    hold_len = thr + $urandom_range(0, 20);
          5:    hold_len = $urandom_range(1, 12);
          default: begin
            hold_len = 1;
            flood    = (thr <= 30);
          end
        endcase
      end
      if (hold_len < 1) begin
        hold_len = 1;
      end

      if (flood) begin
        // Press every key to the threshold and release, eight times over,
        // with no pops: more events than the ring holds.
        for (int r = 0; r < 8; r++) begin
          repeat ((thr < 1) ? 1 : thr) begin
            send_request(KIND_TICK, 3'b000);
            sent++;
          end
          send_request(KIND_TICK, 3'b111);
          sent++;
        end
        pops = QUEUE_DEPTH + 3;
      end else begin
        for (int t = 0; t < hold_len; t++) begin
          noisy = pins;
          // Bounce one pin for a single sample now and then.
          if ($urandom_range(0, 19) == 0) begin
            noisy[$urandom_range(0, 2)] = ~noisy[$urandom_range(0, 2)];
          end
          send_request(KIND_TICK, noisy);
          sent++;
          if ($urandom_range(0, 7) == 0) begin
            send_request(KIND_POP, 3'($urandom_range(0, 7)));
            sent++;
          end
        end
        case ($urandom_range(0, 7))
          0:       pops = 0;
          1:       pops = QUEUE_DEPTH + 3;
          default: pops = $urandom_range(1, 4);
        endcase
      end

      repeat (pops) begin
        send_request(KIND_POP, 3'($urandom_range(0, 7)));
        sent++;
      end
    end
    calm = 1'b0;
  endtask

  // Receiver: stall in random bursts, with free stretches between them.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: threshold of one, so every fresh press raises an event.
    write_threshold(HOLD_W'(1));
    send_request(KIND_POP,  3'b111);  // empty ring answers key 3, status up
    send_request(KIND_POP,  3'b000);  // pin field is ignored on a pop
    send_request(KIND_TICK, 3'b000);  // all three keys at once, queued in key order
    send_request(KIND_TICK, 3'b000);  // still held: no repeat event
    send_request(KIND_POP,  3'b101);
    send_request(KIND_POP,  3'b010);
    send_request(KIND_TICK, 3'b111);  // release clears counts, no release event
    send_request(KIND_TICK, 3'b110);
    send_request(KIND_TICK, 3'b101);
    send_request(KIND_TICK, 3'b011);
    repeat (5) send_request(KIND_POP, 3'b111);  // last one finds the ring empty

    // Each phase boundary is also a full pause until all results are in.
    drain_and_settle();
    write_threshold(HOLD_W'(2));
    run_phase(2, 330, 1'b1);  // hold past the counter top: one event, no wrap

    drain_and_settle();
    write_threshold(HOLD_W'(1));
    run_phase(1, 120, 1'b0);

    drain_and_settle();
    write_threshold(HOLD_W'(3));
    run_phase(3, 120, 1'b0);

    drain_and_settle();
    write_threshold(HOLD_W'(254));
    run_phase(254, 280, 1'b0);

    // Threshold at the counter top matches once, on the step to it.
    drain_and_settle();
    write_threshold(HOLD_W'(255));
    run_phase(255, 300, 1'b0);

    // Zero never matches: pops only ever see the empty answer.
    drain_and_settle();
    write_threshold(HOLD_W'(0));
    run_phase(0, 100, 1'b0);

    drain_and_settle();
    begin
      int mid_thr;
      mid_thr = $urandom_range(4, 30);
      write_threshold(HOLD_W'(mid_thr));
      run_phase(mid_thr, 120, 1'b0);
    end

    // Closing stretch at the reset value, full rate on both sides.
    drain_and_settle();
    quiet = 1'b1;
    write_threshold(PRESS_TICKS_RESET);
    run_phase(int'(PRESS_TICKS_RESET), 100, 1'b0);

    drain_and_settle();
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
